// ===== design/lcmf_pkg.sv =====
`default_nettype none
package lcmf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_TEST,
    ST_DIVIDE,
    ST_SEARCH,
    ST_CHECK,
    ST_SCALE,
    ST_SCALE_CHK,
    ST_WRITE,
    ST_NEXT,
    ST_DONE
  } lcmf_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;         // take in a new request
    logic clear;        // clear table, lcm and flags
    logic div_start;    // start a division n / k
    logic div_commit;   // n <= quotient, exponent++
    logic search_reset; // set search index to zero
    logic search_step;  // advance search index
    logic scale_start;  // start multiply lcm by p
    logic scale_commit; // lcm <= product (saturating)
    logic write_entry;  // write prime/exponent entry
    logic set_full;     // set sticky full flag
    logic next_k;       // k <= k + 1, exponent <= 0
    logic take_rest;    // p <= n, e <= 1, n <= 1
    logic out_load;     // load result register
  } lcmf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic divisible;    // remainder is zero
    logic k_sq_le_n;    // k*k <= n
    logic n_gt_one;
    logic have_exp;     // exponent of current k nonzero
    logic search_end;   // index reached entries used
    logic hit;          // table entry matches prime
    logic need_scale;   // exponent rise left to apply
    logic table_avail;  // free entry exists
    logic scale_done;
    logic out_busy;     // result register occupied
  } lcmf_sts_t;

endpackage
`default_nettype wire

// ===== design/lcmf_if.sv =====
`default_nettype none
interface lcmf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        start_new;
  modport source (output valid, output value, output start_new, input ready);
  modport sink (input valid, input value, input start_new, output ready);
endinterface

interface lcmf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] lcm_so_far;
  logic        lcm_overflow;
  logic        table_full;
  modport source (output valid, output lcm_so_far, output lcm_overflow,
                  output table_full, input ready);
  modport sink (input valid, input lcm_so_far, input lcm_overflow,
                input table_full, output ready);
endinterface
`default_nettype wire

// ===== design/lcmf_ctrl.sv =====
`default_nettype none
module lcmf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lcmf_pkg::lcmf_sts_t sts,
  output lcmf_pkg::lcmf_cmd_t      cmd
);

  lcmf_pkg::lcmf_state_t state_r, state_nxt;
  logic rest_r, rest_nxt; // handling the leftover prime

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcmf_pkg::ST_IDLE;
      rest_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rest_r  <= rest_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    rest_nxt  = rest_r;
    case (state_r)
      lcmf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lcmf_pkg::ST_TEST;
        rest_nxt = 1'b0;
      end
      lcmf_pkg::ST_TEST: begin
        if (sts.n_gt_one && sts.k_sq_le_n) state_nxt = lcmf_pkg::ST_DIVIDE;
        else if (sts.n_gt_one) begin
          state_nxt = lcmf_pkg::ST_SEARCH;
          rest_nxt  = 1'b1;
        end else state_nxt = lcmf_pkg::ST_DONE;
      end
      lcmf_pkg::ST_DIVIDE: begin
        if (sts.div_done) begin
          if (sts.divisible) state_nxt = lcmf_pkg::ST_START;
          else if (sts.have_exp) state_nxt = lcmf_pkg::ST_SEARCH;
          else state_nxt = lcmf_pkg::ST_NEXT;
        end
      end
      lcmf_pkg::ST_START: state_nxt = lcmf_pkg::ST_DIVIDE;
      lcmf_pkg::ST_SEARCH: state_nxt = lcmf_pkg::ST_CHECK;
      lcmf_pkg::ST_CHECK: begin
        if (!sts.search_end) begin
          if (sts.hit) state_nxt = lcmf_pkg::ST_SCALE_CHK;
          else state_nxt = lcmf_pkg::ST_CHECK;
        end else if (sts.table_avail) state_nxt = lcmf_pkg::ST_SCALE_CHK;
        else state_nxt = lcmf_pkg::ST_NEXT;
      end
      lcmf_pkg::ST_SCALE_CHK: begin
        if (sts.need_scale) state_nxt = lcmf_pkg::ST_SCALE;
        else state_nxt = lcmf_pkg::ST_WRITE;
      end
      lcmf_pkg::ST_SCALE: begin
        if (sts.scale_done) state_nxt = lcmf_pkg::ST_SCALE_CHK;
      end
      lcmf_pkg::ST_WRITE: state_nxt = lcmf_pkg::ST_NEXT;
      lcmf_pkg::ST_NEXT: begin
        state_nxt = rest_r ? lcmf_pkg::ST_DONE : lcmf_pkg::ST_TEST;
      end
      lcmf_pkg::ST_DONE: begin
        if (!sts.out_busy) state_nxt = lcmf_pkg::ST_IDLE;
      end
      default: state_nxt = lcmf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lcmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lcmf_pkg::ST_TEST: begin
        if (sts.n_gt_one && sts.k_sq_le_n) cmd.div_start = 1'b1;
        else if (sts.n_gt_one) begin
          cmd.take_rest    = 1'b1;
          cmd.search_reset = 1'b1;
        end
      end
      lcmf_pkg::ST_DIVIDE: begin
        if (sts.div_done && sts.divisible) cmd.div_commit = 1'b1;
        if (sts.div_done && !sts.divisible && sts.have_exp) cmd.search_reset = 1'b1;
      end
      lcmf_pkg::ST_START: cmd.div_start = 1'b1;
      lcmf_pkg::ST_CHECK: begin
        if (!sts.search_end && !sts.hit) cmd.search_step = 1'b1;
        if (sts.search_end && !sts.table_avail) cmd.set_full = 1'b1;
      end
      lcmf_pkg::ST_SCALE_CHK: cmd.scale_start = sts.need_scale;
      lcmf_pkg::ST_SCALE: cmd.scale_commit = sts.scale_done;
      lcmf_pkg::ST_WRITE: cmd.write_entry = 1'b1;
      lcmf_pkg::ST_NEXT: cmd.next_k = 1'b1;
      lcmf_pkg::ST_DONE: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/lcmf_datapath.sv =====
`default_nettype none
module lcmf_datapath #(
  parameter int VALUE_BITS  = 16,
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [15:0]         in_value,
  input  wire logic                in_start_new,
  input  wire lcmf_pkg::lcmf_cmd_t cmd,
  output lcmf_pkg::lcmf_sts_t      sts,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [63:0]              out_lcm_so_far,
  output logic                     out_lcm_overflow,
  output logic                     out_table_full
);

  localparam int VB = VALUE_BITS;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DCW = $clog2(VB + 1);
  localparam int MCW = 7;

  // memories
  logic [VB-1:0] prime_mem [TABLE_DEPTH];
  logic [4:0]    exp_mem   [TABLE_DEPTH];
  logic [VB-1:0] rd_prime_r;
  logic [4:0]    rd_exp_r;
  logic [CW-1:0] rd_idx;

  logic [31:0]   in_ext;
  logic [VB-1:0] n_r, k_r, p_r;
  logic [5:0]    e_r;
  logic [CW-1:0] used_r, idx_r;
  logic          hit_r;
  logic [4:0]    old_exp_r;
  logic [63:0]   lcm_r;
  logic          ovf_r, full_r;

  // divider: restoring, one bit per cycle
  logic [VB-1:0]  q_r, rem_r;
  logic [DCW-1:0] dcnt_r;
  logic           dbusy_r;
  logic [VB:0]    rem_shift, rem_sub;

  // multiplier: shift-add with overflow detection
  logic [63:0]    acc_r, mcand_r;
  logic [VB-1:0]  mplier_r;
  logic [MCW-1:0] mcnt_r;
  logic           mbusy_r, movf_r, mdone_r;
  logic [64:0]    acc_sum;
  logic           mcand_hi;

  logic [63:0] o_lcm_r;
  logic        o_ovf_r, o_full_r, o_valid_r;
  logic [2*VB-1:0] ksq;

  assign in_ext    = 32'(in_value);
  assign rem_shift = {rem_r, q_r[VB-1]};
  assign rem_sub   = rem_shift - {1'b0, k_r};
  assign ksq       = k_r * k_r;
  assign acc_sum   = {1'b0, acc_r} + {1'b0, mcand_r};
  assign mcand_hi  = mcand_r[63];
  // read ahead so the entry under idx_r is ready when the index moves
  assign rd_idx    = cmd.search_step ? idx_r + CW'(1) : idx_r;

  // status
  always_comb begin
    sts.div_done    = !dbusy_r && dcnt_r == '0;
    sts.divisible   = rem_r == '0;
    sts.k_sq_le_n   = ksq <= {{VB{1'b0}}, n_r};
    sts.n_gt_one    = n_r > {{(VB-1){1'b0}}, 1'b1};
    sts.have_exp    = e_r != '0;
    sts.search_end  = idx_r >= used_r;
    sts.hit         = rd_prime_r == p_r;
    sts.need_scale  = {1'b0, old_exp_r} < e_r[4:0] && !(hit_r == 1'b0 && 1'b0);
    sts.table_avail = used_r < CW'(TABLE_DEPTH);
    sts.scale_done  = mdone_r;
    sts.out_busy    = o_valid_r;
  end

  // table read, registered
  always_ff @(posedge clk) begin
    rd_prime_r <= prime_mem[rd_idx[IW-1:0]];
    rd_exp_r   <= exp_mem[rd_idx[IW-1:0]];
    if (cmd.write_entry) begin
      prime_mem[idx_r[IW-1:0]] <= p_r;
      exp_mem[idx_r[IW-1:0]]   <= old_exp_r;
    end
  end

  // factoring state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= in_ext[VB-1:0];
      k_r <= VB'(2);
      e_r <= '0;
    end
    if (cmd.div_commit) begin
      n_r <= q_r;
      e_r <= e_r + 6'd1;
    end
    if (cmd.take_rest) begin
      p_r <= n_r;
      e_r <= 6'd1;
      n_r <= VB'(1);
    end
    if (cmd.div_start) p_r <= k_r;
    if (cmd.next_k) begin
      k_r <= k_r + VB'(1);
      e_r <= '0;
    end
  end

  // search and exponent tracking
  always_ff @(posedge clk) begin
    if (cmd.search_reset) begin
      idx_r     <= '0;
      hit_r     <= 1'b0;
    end else if (cmd.search_step) begin
      idx_r <= idx_r + CW'(1);
    end
    // on entering scale check, latch the old exponent
    if (cmd.search_reset) old_exp_r <= '0;
    else if (!sts.search_end && sts.hit && !hit_r && !cmd.search_step &&
             !cmd.write_entry && !cmd.scale_start && !cmd.scale_commit) begin
      hit_r     <= 1'b1;
      old_exp_r <= rd_exp_r;
    end
    if (cmd.scale_commit) old_exp_r <= old_exp_r + 5'd1;
  end

  // divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= DCW'(VB);
      q_r     <= n_r;
      rem_r   <= '0;
    end else if (dbusy_r) begin
      if (rem_sub[VB]) begin
        rem_r <= rem_shift[VB-1:0];
        q_r   <= {q_r[VB-2:0], 1'b0};
      end else begin
        rem_r <= rem_sub[VB-1:0];
        q_r   <= {q_r[VB-2:0], 1'b1};
      end
      dcnt_r <= dcnt_r - DCW'(1);
      if (dcnt_r == DCW'(1)) dbusy_r <= 1'b0;
    end
  end

  // multiplier lcm * p with saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
    end else if (cmd.scale_start) begin
      mbusy_r  <= 1'b1;
      mdone_r  <= 1'b0;
      acc_r    <= '0;
      mcand_r  <= lcm_r;
      mplier_r <= p_r;
      movf_r   <= 1'b0;
      mcnt_r   <= MCW'(VB);
    end else if (mbusy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_sum[63:0];
        if (acc_sum[64]) movf_r <= 1'b1;
      end
      mcand_r  <= {mcand_r[62:0], 1'b0};
      mplier_r <= mplier_r >> 1;
      if (mcand_hi && (mplier_r >> 1) != '0) movf_r <= 1'b1;
      mcnt_r <= mcnt_r - MCW'(1);
      if (mcnt_r == MCW'(1)) begin
        mbusy_r <= 1'b0;
        mdone_r <= 1'b1;
      end
    end else begin
      mdone_r <= 1'b0;
    end
  end

  // lcm, table count and sticky flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcm_r  <= 64'd1;
      used_r <= '0;
      ovf_r  <= 1'b0;
      full_r <= 1'b0;
    end else begin
      if (cmd.load && in_start_new) begin
        lcm_r  <= 64'd1;
        used_r <= '0;
        ovf_r  <= 1'b0;
        full_r <= 1'b0;
      end
      if (cmd.scale_commit) begin
        if (movf_r || ovf_r) begin
          lcm_r <= '1;
          ovf_r <= 1'b1;
        end else lcm_r <= acc_r;
      end
      if (cmd.set_full) full_r <= 1'b1;
      if (cmd.write_entry && !hit_r) used_r <= used_r + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) o_valid_r <= 1'b0;
    else if (cmd.out_load) o_valid_r <= 1'b1;
    else if (out_ready) o_valid_r <= 1'b0;
    if (cmd.out_load) begin
      o_lcm_r  <= lcm_r;
      o_ovf_r  <= ovf_r;
      o_full_r <= full_r;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_lcm_so_far   = o_lcm_r;
  assign out_lcm_overflow = o_ovf_r;
  assign out_table_full   = o_full_r;

endmodule
`default_nettype wire

// ===== design/lcm_accumulator_by_factorization_core.sv =====
// running lcm of a stream of unsigned values, by trial-division factoring
// in channel: value and start_new; start_new clears the prime table, the
//   lcm (back to 1) and both sticky flags before the value is taken in
// out channel: lcm_so_far, lcm_overflow, table_full, one request per input
// one value at a time: the input is ready only while no value is being
//   factored; each candidate divisor costs a restoring divide, each
//   table search visits the used entries in turn, each exponent step
//   costs a shift-add multiply of the 64-bit lcm
// latency grows with the number of trial divisors: a large prime
//   needs about sqrt(value) divides
// the lcm saturates at all ones and sets lcm_overflow until start_new
// a prime that finds no free table entry is dropped and sets table_full
// reset (synchronous, active low) clears the lcm to 1, the table count and
//   both flags; no request is pending after reset
// when the receiver stalls the result is held in the output register and
//   the next value is accepted, but its result waits until the held one is taken
`default_nettype none
module lcm_accumulator_by_factorization_core #(
  parameter int VALUE_BITS  = 16,
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lcmf_in_if.sink     in_ch,
  lcmf_out_if.source  out_ch
);

  lcmf_pkg::lcmf_cmd_t cmd;
  lcmf_pkg::lcmf_sts_t sts;

  lcmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcmf_datapath #(
    .VALUE_BITS  (VALUE_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_ch.value),
    .in_start_new     (in_ch.start_new),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_lcm_so_far   (out_ch.lcm_so_far),
    .out_lcm_overflow (out_ch.lcm_overflow),
    .out_table_full   (out_ch.table_full)
  );

endmodule
`default_nettype wire

// ===== design/lcmf_checker.sv =====
`default_nettype none
module lcmf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_lcm_so_far,
  input wire logic        out_lcm_overflow
);

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lcm_so_far))
    else $error("result changed under stall");

  // overflow saturates the lcm
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lcm_overflow |-> out_lcm_so_far == 64'hFFFF_FFFF_FFFF_FFFF)
    else $error("overflow without saturation");

  // lcm is never zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lcm_so_far != 64'd0)
    else $error("zero lcm");

  // one value at a time: no acceptance right after one
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

endmodule

bind lcm_accumulator_by_factorization_core lcmf_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_lcm_so_far   (out_ch.lcm_so_far),
  .out_lcm_overflow (out_ch.lcm_overflow)
);
`default_nettype wire
